// File: rtl/cbpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbpb_pkg
// Shared types and constants of the class pacing and bandwidth tracker.
// ----------------------------------------------------------------------------
package cbpb_pkg;

    localparam logic [1:0] OP_RESERVE  = 2'd0;
    localparam logic [1:0] OP_MARK     = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;

    localparam logic [1:0] REG_BORROW_EN = 2'd0;
    localparam logic [1:0] REG_WINDOW    = 2'd1;
    localparam logic [1:0] REG_SPACING   = 2'd2;

    localparam logic [31:0] WINDOW_RESET  = 32'd5000;
    localparam logic [31:0] SPACING_RESET = 32'd8000;
    localparam logic [19:0] US_PER_SEC    = 20'd1000000;
    localparam int          DIV_STEPS     = 64;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  class_index;
        logic [63:0] time_us;
        logic [63:0] dispatch_time_us;
        logic [31:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [63:0] submit_time_us;
        logic        class_valid;
        logic        throttled;
        logic [63:0] ewma_bandwidth;
        logic [63:0] total_bytes;
        logic [63:0] total_requests;
        logic [63:0] first_completion_us;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic reserve;
        logic mark;
        logic complete;
        logic div_step;
        logic blend;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic       item_ok;
        logic [1:0] opcode;
        logic       borrow_go;
        logic       hit_now;
        logic       scan_last;
        logic       blend_ok;
        logic       div_done;
        logic       out_free;
    } status_t;

endpackage
`default_nettype wire

// File: rtl/class_borrow_pacing_and_bandwidth.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// class_borrow_pacing_and_bandwidth
// Per-class submit pacing and completion bandwidth tracker.
// ----------------------------------------------------------------------------
// One item is processed at a time. From the accepting edge the sequencer
// decodes the item: an item with a bad class or an unused opcode goes
// straight to emit, and so does a reserve with borrow mode off or for class 0.
// A mark passes through its update state, and so does a completion without a
// usable bandwidth sample. A reserve that scans the higher classes (indices
// below its own) goes at one class per cycle (it stops at the first active
// one). A completion with a usable bandwidth sample runs the 64-step serial
// divider for ceil(bytes * 1e6 / elapsed), then the blend. The next item is
// accepted in the cycle after the result is loaded. The result register lets
// a new item be accepted while the previous result waits to be taken.
module class_borrow_pacing_and_bandwidth
    import cbpb_pkg::*;
#(
    parameter int CLASS_COUNT = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_item
);

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign in_stall = !in_ready;

    cbpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cbpb_datapath #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

// File: rtl/cbpb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbpb_datapath
// Per-class state, configuration, scan compare, serial divider and result
// register.
// ----------------------------------------------------------------------------
module cbpb_datapath
    import cbpb_pkg::*;
#(
    parameter int CLASS_COUNT = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire in_item_t   in_item,
    input  wire cmd_t       cmd,
    output status_t         status,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_item
);

    localparam int IW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

    logic        borrow_reg;
    logic [31:0] window_reg;
    logic [31:0] spacing_reg;

    logic [63:0] last_reg   [CLASS_COUNT];
    logic [63:0] slot_reg   [CLASS_COUNT];
    logic [63:0] wstart_reg [CLASS_COUNT];
    logic [63:0] bytes_reg  [CLASS_COUNT];
    logic [63:0] reqs_reg   [CLASS_COUNT];
    logic [63:0] bw_reg     [CLASS_COUNT];

    in_item_t    item_reg;
    logic [IW-1:0] idx_reg;
    logic        hit_reg;
    logic        thr_reg;
    logic [63:0] submit_reg;
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic [IW-1:0] cls;
    logic        cls_in_range;
    logic [63:0] last_h;
    logic [63:0] slot_c;
    logic [63:0] slot_max;
    logic [51:0] product;
    logic [64:0] trial;
    logic        trial_ge;
    logic [63:0] inst;
    logic [63:0] bw_old;
    logic [63:0] blended;

    assign cls          = item_reg.class_index[IW-1:0];
    assign cls_in_range = {1'b0, item_reg.class_index} < 5'(CLASS_COUNT);
    assign last_h       = last_reg[idx_reg];
    assign slot_c       = slot_reg[cls];
    assign slot_max     = (slot_c < item_reg.time_us) ? item_reg.time_us : slot_c;
    assign product      = item_reg.byte_count * US_PER_SEC;
    assign trial        = {rem_reg, quo_reg[63]};
    assign trial_ge     = trial >= {1'b0, den_reg};
    assign inst         = quo_reg + {63'd0, rem_reg != 64'd0};
    assign bw_old       = bw_reg[cls];
    assign blended      = (bw_old == 64'd0) ? inst
                          : (((bw_old << 3) - bw_old + inst) >> 3);

    always_comb
    begin
        status.item_ok   = cls_in_range && (item_reg.opcode <= OP_COMPLETE);
        status.opcode    = item_reg.opcode;
        status.borrow_go = borrow_reg && (item_reg.class_index != 4'd0);
        status.hit_now   = (last_h != 64'd0) && (item_reg.time_us >= last_h)
                           && ((item_reg.time_us - last_h) <= {32'd0, window_reg});
        status.scan_last = ({1'b0, idx_reg} + 1'b1) == {1'b0, cls};
        status.blend_ok  = (item_reg.dispatch_time_us != 64'd0)
                           && (item_reg.time_us > item_reg.dispatch_time_us);
        status.div_done  = cnt_reg == 7'(DIV_STEPS);
        status.out_free  = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            borrow_reg  <= 1'b0;
            window_reg  <= WINDOW_RESET;
            spacing_reg <= SPACING_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BORROW_EN: borrow_reg  <= cfg_data[0];
                REG_WINDOW:    window_reg  <= cfg_data;
                REG_SPACING:   spacing_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                last_reg[i]   <= '0;
                slot_reg[i]   <= '0;
                wstart_reg[i] <= '0;
                bytes_reg[i]  <= '0;
                reqs_reg[i]   <= '0;
                bw_reg[i]     <= '0;
            end
        end
        else
        begin
            if (cmd.reserve)
                slot_reg[cls] <= hit_reg ? slot_max + {32'd0, spacing_reg} : 64'd0;
            if (cmd.mark || cmd.complete)
                last_reg[cls] <= item_reg.time_us;
            if (cmd.complete)
            begin
                if (wstart_reg[cls] == 64'd0)
                    wstart_reg[cls] <= item_reg.time_us;
                bytes_reg[cls] <= bytes_reg[cls] + {32'd0, item_reg.byte_count};
                reqs_reg[cls]  <= reqs_reg[cls] + 64'd1;
            end
            if (cmd.blend && inst != 64'd0)
                bw_reg[cls] <= blended;
        end
    end

    // item registers and divider
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg   <= in_item;
            idx_reg    <= '0;
            hit_reg    <= 1'b0;
            thr_reg    <= 1'b0;
            submit_reg <= in_item.time_us;
        end
        if (cmd.scan_step)
        begin
            hit_reg <= hit_reg | status.hit_now;
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.reserve && hit_reg)
        begin
            submit_reg <= slot_max;
            thr_reg    <= 1'b1;
        end
        if (cmd.complete)
        begin
            quo_reg <= {12'd0, product};
            rem_reg <= '0;
            den_reg <= item_reg.time_us - item_reg.dispatch_time_us;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
            quo_reg <= {quo_reg[62:0], trial_ge};
            cnt_reg <= cnt_reg + 7'd1;
        end
        if (cmd.emit)
        begin
            out_reg.submit_time_us      <= submit_reg;
            out_reg.class_valid         <= status.item_ok;
            out_reg.throttled           <= thr_reg;
            out_reg.ewma_bandwidth      <= status.item_ok ? bw_reg[cls] : 64'd0;
            out_reg.total_bytes         <= status.item_ok ? bytes_reg[cls] : 64'd0;
            out_reg.total_requests      <= status.item_ok ? reqs_reg[cls] : 64'd0;
            out_reg.first_completion_us <= status.item_ok ? wstart_reg[cls] : 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule
`default_nettype wire

// File: rtl/cbpb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbpb_ctrl
// Sequencer: decode, higher-class scan, state update, divide, blend, emit.
// ----------------------------------------------------------------------------
module cbpb_ctrl
    import cbpb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECODE = 9'b000000010,
        ST_SCAN   = 9'b000000100,
        ST_RESV   = 9'b000001000,
        ST_MARK   = 9'b000010000,
        ST_CMPL   = 9'b000100000,
        ST_DIV    = 9'b001000000,
        ST_BLEND  = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (!status.item_ok)
                    state_next = ST_EMIT;
                else if (status.opcode == OP_RESERVE)
                    state_next = status.borrow_go ? ST_SCAN : ST_EMIT;
                else if (status.opcode == OP_MARK)
                    state_next = ST_MARK;
                else
                    state_next = ST_CMPL;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.hit_now || status.scan_last)
                    state_next = ST_RESV;
            end
            ST_RESV:
            begin
                cmd.reserve = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_CMPL:
            begin
                cmd.complete = 1'b1;
                state_next   = status.blend_ok ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_BLEND;
                else
                    cmd.div_step = 1'b1;
            end
            ST_BLEND:
            begin
                cmd.blend  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the result register can take the item
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire
